/* rtl/rler_pkg.sv */
// Shared types and constants of the byte run-length encoder.
`default_nettype none

package rler_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 8;
    localparam int WORD_W = 64;
    localparam int CNT_W  = 4;

    // A literal header is this base plus the literal length.
    localparam logic [BYTE_W-1:0] LIT_BASE = 8'd127;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        CMD_REPEAT,
        CMD_LITERAL,
        CMD_EMPTY
    } t_cmd_kind;

    // One flush job handed from the front end to the emitter.
    typedef struct packed {
        t_cmd_kind         kind;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] rbyte;
        logic              eos;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_BYTE,
        BK_LIT
    } t_back_state;

    // One encoded byte offered to the packer.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              nobyte;
        logic              last;
        logic              eos;
    } t_byte_req;

endpackage

`default_nettype wire

/* rtl/rler_front.sv */
// Front end: tracks the pending run and issues flush jobs.
`default_nettype none

module rler_front #(
    parameter int MAX_RUN = 128
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    input  wire                           i_kind,
    input  wire [rler_pkg::BYTE_W-1:0]    i_data,
    output logic                          o_full,
    input  wire                           i_cmd_full,
    output logic                          o_cmd_push,
    output rler_pkg::t_cmd                o_cmd,
    input  wire                           i_lit_done,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_RUN)-1:0]    o_wr_addr,
    output logic [rler_pkg::BYTE_W-1:0]   o_wr_data
);

    localparam int AW = $clog2(MAX_RUN);
    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int LW = rler_pkg::LEN_W;

    logic [CW-1:0]               r_count, n_count;
    logic                        r_rep, n_rep;
    logic                        r_busy, n_busy;
    logic [rler_pkg::BYTE_W-1:0] r_last_byte, n_last_byte;
    logic [CW:0]                 cnt_inc;
    logic                        accept;

    assign o_full    = i_cmd_full || r_busy;
    assign accept    = i_push && !o_full;
    assign cnt_inc   = {1'b0, r_count} + (CW+1)'(1);
    assign o_wr_data = i_data;

    always_comb begin
        n_count     = r_count;
        n_rep       = r_rep;
        n_last_byte = r_last_byte;
        n_busy      = r_busy && !i_lit_done;
        o_cmd_push  = 1'b0;
        o_cmd       = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        if (accept) begin
            if (i_kind == rler_pkg::KIND_DATA) begin
                n_last_byte = i_data;
                if (r_count == '0) begin
                    o_wr_en = 1'b1;
                    n_count = CW'(1);
                    n_rep   = 1'b0;
                end else if (r_rep) begin
                    if (i_data != r_last_byte) begin
                        o_cmd_push  = 1'b1;
                        o_cmd.kind  = rler_pkg::CMD_REPEAT;
                        o_cmd.len   = LW'(r_count);
                        o_cmd.rbyte = r_last_byte;
                        o_wr_en     = 1'b1;
                        n_count     = CW'(1);
                        n_rep       = 1'b0;
                    end else if (cnt_inc >= (CW+1)'(MAX_RUN)) begin
                        // The run is at its limit: flush all but the new byte.
                        o_cmd_push  = 1'b1;
                        o_cmd.kind  = rler_pkg::CMD_REPEAT;
                        o_cmd.len   = LW'(r_count);
                        o_cmd.rbyte = i_data;
                        o_wr_en     = 1'b1;
                        n_count     = CW'(1);
                        n_rep       = 1'b0;
                    end else begin
                        n_count = CW'(cnt_inc);
                    end
                end else begin
                    if (i_data == r_last_byte) begin
                        // The last literal byte turns into a repeat of two.
                        if (r_count > CW'(1)) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = rler_pkg::CMD_LITERAL;
                            o_cmd.len  = LW'(r_count - CW'(1));
                        end
                        n_count = CW'(2);
                        n_rep   = 1'b1;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_count[AW-1:0];
                        if (cnt_inc >= (CW+1)'(MAX_RUN)) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = rler_pkg::CMD_LITERAL;
                            o_cmd.len  = LW'(cnt_inc);
                            n_count    = '0;
                            n_rep      = 1'b0;
                        end else begin
                            n_count = CW'(cnt_inc);
                        end
                    end
                end
            end else begin
                o_cmd_push  = 1'b1;
                o_cmd.eos   = 1'b1;
                o_cmd.len   = LW'(r_count);
                o_cmd.rbyte = r_last_byte;
                if (r_rep) begin
                    o_cmd.kind = rler_pkg::CMD_REPEAT;
                end else if (r_count != '0) begin
                    o_cmd.kind = rler_pkg::CMD_LITERAL;
                end else begin
                    o_cmd.kind = rler_pkg::CMD_EMPTY;
                end
                n_count = '0;
                n_rep   = 1'b0;
            end
        end
        if (o_cmd_push && o_cmd.kind == rler_pkg::CMD_LITERAL) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rep   <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rep   <= n_rep;
            r_busy  <= n_busy;
        end
        r_last_byte <= n_last_byte;
    end

endmodule

`default_nettype wire

/* rtl/rler_cmd_fifo.sv */
// Two-entry queue of flush jobs between the front end and the emitter.
`default_nettype none

module rler_cmd_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  rler_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output rler_pkg::t_cmd o_cmd
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    rler_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [NW-1:0]  r_cnt;
    logic           push_ok, pop_ok;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
        if (push_ok) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/rler_back.sv */
// Emitter: holds the literal buffer and turns flush jobs into a byte sequence.
`default_nettype none

module rler_back #(
    parameter int MAX_RUN = 128
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cmd_valid,
    input  rler_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_pop,
    input  wire                          i_wr_en,
    input  wire [$clog2(MAX_RUN)-1:0]    i_wr_addr,
    input  wire [rler_pkg::BYTE_W-1:0]   i_wr_data,
    output rler_pkg::t_byte_req          o_req,
    input  wire                          i_ready,
    output logic                         o_lit_done
);

    localparam int AW        = $clog2(MAX_RUN);
    localparam int BUF_DEPTH = 1 << AW;
    localparam int LW        = rler_pkg::LEN_W;

    logic [rler_pkg::BYTE_W-1:0] mem [BUF_DEPTH];
    logic [rler_pkg::BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]               r_idx, rd_addr;
    rler_pkg::t_back_state       r_state, n_state;
    rler_pkg::t_cmd              r_cmd;
    logic                        lit_last;

    assign lit_last = (LW'(r_idx) + LW'(1)) == r_cmd.len;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rler_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = rler_pkg::BK_HEAD;
                end
            end
            rler_pkg::BK_HEAD: begin
                if (i_ready) begin
                    case (r_cmd.kind)
                        rler_pkg::CMD_REPEAT:  n_state = rler_pkg::BK_BYTE;
                        rler_pkg::CMD_LITERAL: n_state = rler_pkg::BK_LIT;
                        default:               n_state = rler_pkg::BK_IDLE;
                    endcase
                end
            end
            rler_pkg::BK_BYTE: begin
                if (i_ready) begin
                    n_state = rler_pkg::BK_IDLE;
                end
            end
            rler_pkg::BK_LIT: begin
                if (i_ready && lit_last) begin
                    n_state = rler_pkg::BK_IDLE;
                end
            end
            default: n_state = rler_pkg::BK_IDLE;
        endcase
    end

    // Outputs. The read address points at the index current in the next cycle
    // (0 in the header state), so in BK_LIT the registered read data matches r_idx.
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_req      = '0;
        o_lit_done = 1'b0;
        rd_addr    = r_idx;
        case (r_state)
            rler_pkg::BK_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            rler_pkg::BK_HEAD: begin
                o_req.valid = 1'b1;
                rd_addr     = '0;
                case (r_cmd.kind)
                    rler_pkg::CMD_REPEAT:  o_req.data = r_cmd.len;
                    rler_pkg::CMD_LITERAL: o_req.data = rler_pkg::LIT_BASE + r_cmd.len;
                    default: begin
                        o_req.nobyte = 1'b1;
                        o_req.last   = 1'b1;
                        o_req.eos    = r_cmd.eos;
                    end
                endcase
            end
            rler_pkg::BK_BYTE: begin
                o_req.valid = 1'b1;
                o_req.data  = r_cmd.rbyte;
                o_req.last  = 1'b1;
                o_req.eos   = r_cmd.eos;
            end
            rler_pkg::BK_LIT: begin
                o_req.valid = 1'b1;
                o_req.data  = r_rd_data;
                o_req.last  = lit_last;
                o_req.eos   = r_cmd.eos && lit_last;
                o_lit_done  = i_ready && lit_last;
                if (i_ready) begin
                    rd_addr = r_idx + AW'(1);
                end
            end
            default: o_cmd_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rler_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == rler_pkg::BK_HEAD && i_ready) begin
            r_idx <= '0;
        end else if (r_state == rler_pkg::BK_LIT && i_ready) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/rler_packer.sv */
// Packer: gathers encoded bytes into words and holds the output register.
`default_nettype none

module rler_packer #(
    parameter int OUT_BYTES = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  rler_pkg::t_byte_req          i_req,
    output logic                         o_ready,
    input  wire                          i_pop,
    output logic                         o_empty,
    output logic [rler_pkg::WORD_W-1:0]  o_out_word,
    output logic [rler_pkg::CNT_W-1:0]   o_byte_count,
    output logic                         o_last,
    output logic                         o_stream_end
);

    localparam int WB = OUT_BYTES * rler_pkg::BYTE_W;
    localparam int CW = rler_pkg::CNT_W;
    localparam int OW = rler_pkg::WORD_W;

    logic [WB-1:0] r_word, n_word, merged;
    logic [CW-1:0] r_fill, n_fill, fill_inc;
    logic          r_out_valid, n_out_valid;
    logic          completing, out_free, take;

    always_comb begin
        merged = r_word;
        for (int j = 0; j < OUT_BYTES; j++) begin
            if (!i_req.nobyte && r_fill == CW'(j)) begin
                merged[j*rler_pkg::BYTE_W +: rler_pkg::BYTE_W] = i_req.data;
            end
        end
    end

    assign fill_inc   = i_req.nobyte ? r_fill : r_fill + CW'(1);
    assign completing = i_req.last || (fill_inc == CW'(OUT_BYTES));
    assign out_free   = !r_out_valid || i_pop;
    assign o_ready    = !completing || out_free;
    assign take       = i_req.valid && o_ready;
    assign o_empty    = !r_out_valid;

    always_comb begin
        n_word      = r_word;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !i_pop;
        if (take) begin
            if (completing) begin
                n_out_valid = 1'b1;
                n_word      = '0;
                n_fill      = '0;
            end else begin
                n_word = merged;
                n_fill = fill_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_word      <= n_word;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        if (take && completing) begin
            o_out_word   <= OW'(merged);
            o_byte_count <= fill_inc;
            o_last       <= i_req.last;
            o_stream_end <= i_req.eos;
        end
    end

endmodule

`default_nettype wire

/* rtl/byte_rle_run_encoder.sv */
// Top level of the byte run-length encoder.
`default_nettype none

// Byte stream in, run-length coded words out. Both sides look like a queue.
// A word goes in at a clock edge with push high and full low; i_kind 0 is a
// data byte on i_data, i_kind 1 ends the stream and flushes what is pending.
// Results are read like a queue: while empty is low the oldest word is on
// o_out_word (first byte in bits 7:0), o_byte_count, o_last, o_stream_end,
// and pop takes it. A repeat run comes out as count then byte, a literal as
// 127 plus its length then its bytes, packed OUT_BYTES bytes to a word.
// The front end tracks the pending run and takes a data byte every cycle as
// long as its job queue has room and no literal flush is under way. The
// emitter fetches a flush job from the queue, then offers its header and
// each further byte in turn. During a literal flush the buffer is being
// read, so full stays high from the word that causes it until its last
// byte reaches the packer.
// A stalled reader holds the output register; the packer and emitter then
// stop, the job queue fills and full rises. Reset empties all queues and
// clears the pending run; the buffer contents are never read before written.
module byte_rle_run_encoder #(
    parameter int MAX_RUN   = 128,
    parameter int OUT_BYTES = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire                          i_kind,
    input  wire [rler_pkg::BYTE_W-1:0]   i_data,
    output logic                         empty,
    input  wire                          pop,
    output logic [rler_pkg::WORD_W-1:0]  o_out_word,
    output logic [rler_pkg::CNT_W-1:0]   o_byte_count,
    output logic                         o_last,
    output logic                         o_stream_end
);

    localparam int AW = $clog2(MAX_RUN);

    // Jobs from the front end into the queue, and from the queue to the emitter.
    logic                        cmd_push, cmd_full, cmd_valid, cmd_pop;
    rler_pkg::t_cmd              cmd_in, cmd_out;
    // Buffer write port owned by the front end.
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [rler_pkg::BYTE_W-1:0] wr_data;
    // Tells the front end that the buffer is free again.
    logic                        lit_done;
    rler_pkg::t_byte_req         req;
    logic                        req_ready;

    rler_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_kind     (i_kind),
        .i_data     (i_data),
        .o_full     (full),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_lit_done (lit_done),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    rler_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    rler_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_req       (req),
        .i_ready     (req_ready),
        .o_lit_done  (lit_done)
    );

    rler_packer #(
        .OUT_BYTES (OUT_BYTES)
    ) u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_ready      (req_ready),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_word   (o_out_word),
        .o_byte_count (o_byte_count),
        .o_last       (o_last),
        .o_stream_end (o_stream_end)
    );

endmodule

`default_nettype wire

/* rtl/rler_checker.sv */
// Port-level checks of the byte run-length encoder and their binding.
`default_nettype none

module rler_checker #(
    parameter int OUT_BYTES = 8
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          empty,
    input wire                          pop,
    input wire [rler_pkg::WORD_W-1:0]   o_out_word,
    input wire [rler_pkg::CNT_W-1:0]    o_byte_count,
    input wire                          o_last,
    input wire                          o_stream_end
);

    // Nothing is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // The stream end marker only sits on the final word of an item.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stream_end) |-> o_last)
        else $error("stream end on a word that is not last");

    // A word without bytes is only the empty end result, and it is all zero.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_count == '0) |-> (o_stream_end && o_out_word == '0))
        else $error("bad zero-byte word");

    // Only the last word of an item may be partly filled.
    a_full_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> (o_byte_count == 4'(OUT_BYTES)))
        else $error("partial word before the end of an item");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_word)
                              && $stable(o_byte_count)))
        else $error("waiting word changed");

endmodule

bind byte_rle_run_encoder rler_checker #(.OUT_BYTES(OUT_BYTES)) u_rler_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the byte run-length encoder.

// Tracks the pending run the way the encoder does and keeps the coded words
// that the encoder still owes, oldest first.
class rle_tracker;

    localparam int RUN_LIMIT  = 128;
    localparam int PACK_BYTES = 8;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        last;
        logic        eos;
    } coded_word_t;

    logic [7:0]  held [RUN_LIMIT];
    int unsigned held_cnt;
    bit          repeating;
    logic [7:0]  coded [$];
    coded_word_t due_q [$];
    int unsigned fails;

    function new();
        held_cnt  = 0;
        repeating = 1'b0;
        fails     = 0;
    endfunction

    function void add_repeat(int unsigned n);
        coded.push_back(8'(n));
        coded.push_back(held[0]);
    endfunction

    function void add_literal(int unsigned n);
        coded.push_back(8'(rler_pkg::LIT_BASE + n));
        for (int i = 0; i < n; i++) begin
            coded.push_back(held[i]);
        end
    endfunction

    // Called once per accepted input word.
    function void take_input(logic kind, logic [7:0] d);
        coded_word_t r;
        int          base;
        coded.delete();
        if (kind == rler_pkg::KIND_DATA) begin
            if (held_cnt == 0) begin
                held[0]   = d;
                held_cnt  = 1;
                repeating = 1'b0;
            end else if (repeating) begin
                if (d != held[0]) begin
                    add_repeat(held_cnt);
                    held[0]   = d;
                    held_cnt  = 1;
                    repeating = 1'b0;
                end else begin
                    held_cnt++;
                    // A full-length repeat is cut one short; the new byte stays.
                    if (held_cnt >= RUN_LIMIT) begin
                        add_repeat(held_cnt - 1);
                        held_cnt  = 1;
                        repeating = 1'b0;
                    end
                end
            end else if (d == held[held_cnt - 1]) begin
                // The matching byte leaves the literal and opens a repeat of two.
                if (held_cnt > 1) begin
                    add_literal(held_cnt - 1);
                end
                held[0]   = d;
                held_cnt  = 2;
                repeating = 1'b1;
            end else begin
                held[held_cnt] = d;
                held_cnt++;
                if (held_cnt >= RUN_LIMIT) begin
                    add_literal(held_cnt);
                    held_cnt  = 0;
                    repeating = 1'b0;
                end
            end
        end else begin
            if (repeating && held_cnt >= 2) begin
                add_repeat(held_cnt);
            end else if (held_cnt >= 1) begin
                add_literal(held_cnt);
            end
            held_cnt  = 0;
            repeating = 1'b0;
        end

        if (coded.size() == 0) begin
            // Data that closes nothing owes no word; an end item owes an empty one.
            if (kind == rler_pkg::KIND_END) begin
                r.word = '0;
                r.cnt  = '0;
                r.last = 1'b1;
                r.eos  = 1'b1;
                due_q.push_back(r);
            end
            return;
        end

        for (base = 0; base < coded.size(); base += PACK_BYTES) begin
            r.word = '0;
            r.cnt  = '0;
            for (int j = 0; j < PACK_BYTES && base + j < coded.size(); j++) begin
                r.word[8*j +: 8] = coded[base + j];
                r.cnt++;
            end
            r.last = (base + PACK_BYTES >= coded.size());
            r.eos  = r.last && (kind == rler_pkg::KIND_END);
            due_q.push_back(r);
        end
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fails++;
        end
    endfunction

    // Called once per word popped from the encoder.
    function void check_word(logic [63:0] word, logic [3:0] cnt, logic last, logic eos);
        coded_word_t r;
        if (due_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h cnt %0d last %b end %b",
                     $time, word, cnt, last, eos);
            fails++;
            return;
        end
        r = due_q.pop_front();
        report("o_out_word", r.word, word);
        report("o_byte_count", 64'(r.cnt), 64'(cnt));
        report("o_last", 64'(r.last), 64'(last));
        report("o_stream_end", 64'(r.eos), 64'(eos));
    endfunction

endclass

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 800_000;
    localparam int RAND_ITEMS   = 360;
    localparam int DRAIN_CYCLES = 40;

    // Every input of the encoder starts at a known value.
    logic                               i_clk   = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               push    = 1'b0;
    logic                               i_kind  = rler_pkg::KIND_DATA;
    logic [rler_pkg::BYTE_W-1:0]        i_data  = '0;
    logic                               pop     = 1'b0;
    logic                               full;
    logic                               empty;
    logic [rler_pkg::WORD_W-1:0]        o_out_word;
    logic [rler_pkg::CNT_W-1:0]         o_byte_count;
    logic                               o_last;
    logic                               o_stream_end;

    rle_tracker tracker = new();

    // Stimulus is laid out in full before the first word is pushed.
    logic       stim_kind [$];
    logic [7:0] stim_data [$];
    logic [7:0] prev_byte = '0;

    // Percentages of cycles in which the sender or the receiver holds back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    byte_rle_run_encoder u_dut (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_kind,
        .i_data,
        .empty,
        .pop,
        .o_out_word,
        .o_byte_count,
        .o_last,
        .o_stream_end
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the encoder hangs; sized far beyond the slowest correct run.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("** byte_rle_run_encoder: FAILED **");
        $finish;
    end

    // Input side: a word is taken at an edge where push is high and full is low.
    // The values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            tracker.take_input(i_kind, i_data);
        end
    end

    // Output side: check the word taken at this edge, then decide whether the
    // receiver pops in the next cycle. Popping while empty is harmless.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                tracker.check_word(o_out_word, o_byte_count, o_last, o_stream_end);
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void add_item(logic k, logic [7:0] d);
        stim_kind.push_back(k);
        stim_data.push_back(d);
        if (k == rler_pkg::KIND_DATA) begin
            prev_byte = d;
        end
    endfunction

    function automatic void add_end();
        add_item(rler_pkg::KIND_END, 8'($urandom_range(255)));
    endfunction

    // One byte repeated; whether it continues the run before is left to chance.
    function automatic void add_repeat_run(int len);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        for (int i = 0; i < len; i++) begin
            add_item(rler_pkg::KIND_DATA, b);
        end
    endfunction

    // Bytes that each differ from the one before, so the literal keeps growing.
    function automatic void add_literal_run(int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            do begin
                b = 8'($urandom_range(255));
            end while (b == prev_byte);
            add_item(rler_pkg::KIND_DATA, b);
        end
    endfunction

    // Bytes mostly from a tiny alphabet, so short repeats and literals mix freely.
    function automatic void add_noise(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) begin
                add_item(rler_pkg::KIND_DATA, 8'($urandom_range(255)));
            end else begin
                add_item(rler_pkg::KIND_DATA, 8'($urandom_range(3)));
            end
        end
    endfunction

    function automatic int run_len(int short_max);
        if ($urandom_range(14) == 0) begin
            return $urandom_range(135, 120);
        end
        return $urandom_range(short_max, 1);
    endfunction

    function automatic void build_stimulus();
        int pick;
        int goal;

        // End with nothing pending gives the empty word; its data is ignored.
        add_item(rler_pkg::KIND_END, 8'hA5);
        // A lone byte is flushed as a literal of one.
        add_item(rler_pkg::KIND_DATA, 8'h00);
        add_end();
        // A short repeat closed by the end item.
        add_item(rler_pkg::KIND_DATA, 8'hFF);
        add_item(rler_pkg::KIND_DATA, 8'hFF);
        add_item(rler_pkg::KIND_DATA, 8'hFF);
        add_end();
        // A literal broken by a repeated byte, then a repeat broken by a new byte.
        add_item(rler_pkg::KIND_DATA, 8'h01);
        add_item(rler_pkg::KIND_DATA, 8'h02);
        add_item(rler_pkg::KIND_DATA, 8'h03);
        add_item(rler_pkg::KIND_DATA, 8'h03);
        add_item(rler_pkg::KIND_DATA, 8'h04);
        add_end();
        // A single pending byte turning into a repeat flushes no literal.
        add_item(rler_pkg::KIND_DATA, 8'h10);
        add_item(rler_pkg::KIND_DATA, 8'h10);
        add_item(rler_pkg::KIND_DATA, 8'h80);
        add_item(rler_pkg::KIND_DATA, 8'h7F);
        add_end();
        add_end();
        add_item(rler_pkg::KIND_DATA, 8'h55);
        add_item(rler_pkg::KIND_DATA, 8'hAA);
        add_end();

        // The run limits are reached once each from a clean state, then the
        // rest is mostly well-formed runs with some noise and end items.
        goal = stim_kind.size() + RAND_ITEMS;
        add_repeat_run($urandom_range(131, 128));
        add_end();
        add_literal_run($urandom_range(131, 128));
        add_end();
        while (stim_kind.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                add_repeat_run(run_len(10));
            end else if (pick < 70) begin
                add_literal_run(run_len(12));
            end else if (pick < 85) begin
                add_noise($urandom_range(8, 1));
            end else begin
                add_end();
            end
        end
        add_end();
    endfunction

    // Offer one word and hold it until the encoder takes it.
    task automatic send_word(logic k, logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_kind <= k;
        i_data <= d;
        do @(posedge i_clk); while (full);
    endtask

    // Stop sending until the encoder has handed over every owed word.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (tracker.due_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int n;
        int phase;
        int prev_phase;

        build_stimulus();
        n          = stim_kind.size();
        prev_phase = 0;

        // Synchronous reset, held at the start and never again.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Three phases: a slow receiver, then a slow sender, then full speed.
        // Each phase change waits for the encoder to drain completely first.
        for (int i = 0; i < n; i++) begin
            phase = (i * 3) / n;
            if (phase != prev_phase) begin
                wait_drained();
                prev_phase = phase;
            end
            case (phase)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            send_word(stim_kind[i], stim_data[i]);
        end

        // Everything is in; wait for the owed words, then a little longer so
        // that any stray word still gets caught.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.fails == 0 && tracker.due_q.size() == 0) begin
            $display("** byte_rle_run_encoder: PASSED **");
        end else begin
            if (tracker.due_q.size() != 0) begin
                $display("%0t: %0d expected words never arrived", $time, tracker.due_q.size());
            end
            $display("** byte_rle_run_encoder: FAILED **");
        end
        $finish;
    end

endmodule
